### rtl/cdda_pkg.sv
package cdda_pkg;

    // Field widths of the date and of the request count.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 16;
    // Day accumulator: largest day of month plus the largest count.
    localparam int ACC_W   = COUNT_W + 1;

    // Defaults for the top-level parameters.
    localparam int MAX_YEAR_DEF  = 9999;
    localparam int ADD_WIDTH_DEF = 16;

    // Date used when a load is rejected, and the last month and day of a year.
    localparam logic [YEAR_W-1:0]  FALLBACK_YEAR = YEAR_W'(2020);
    localparam logic [MONTH_W-1:0] JANUARY       = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEBRUARY      = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] DECEMBER      = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   FIRST_DAY     = DAY_W'(1);
    localparam logic [DAY_W-1:0]   LAST_DAY      = DAY_W'(31);

    // Reciprocal of 25 scaled by 2^17; exact floor for any 14-bit year.
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 17;
    localparam int QUOT_W      = 10;
    localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(5243);

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_ADD  = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAP_MUL,
        ST_LEAP_CHK,
        ST_CHECK,
        ST_WALK,
        ST_DONE
    } state_t;

    // Result of one month step of the walk unit.
    typedef struct packed {
        logic [DAY_W-1:0] days;
        logic             fits;
        logic [ACC_W-1:0] rest;
    } walk_t;

    // Length of a month; zero for a code that is not a month.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic              leap);
        logic [DAY_W-1:0] days;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    days = DAY_W'(30);
            4'd2:                                       days = leap ? DAY_W'(29) : DAY_W'(28);
            default:                                    days = '0;
        endcase
        return days;
    endfunction

endpackage

### rtl/cdda_month_walk.sv
module cdda_month_walk (
    input  logic [cdda_pkg::MONTH_W-1:0] month,
    input  logic                         leap,
    input  logic [cdda_pkg::ACC_W-1:0]   acc,
    output cdda_pkg::walk_t              walk
);

    logic [cdda_pkg::DAY_W-1:0] days;

    // Month length, then the one compare and subtract shared by check and walk.
    always_comb begin
        days      = cdda_pkg::month_days(month, leap);
        walk.days = days;
        walk.fits = (acc <= cdda_pkg::ACC_W'(days));
        walk.rest = acc - cdda_pkg::ACC_W'(days);
    end

endmodule

### rtl/calendar_date_day_adder.sv
// Calendar date day adder.
// The block holds one Gregorian date. Each item on the s_ channel is either
// a load (s_tuser low), which checks year_in, month_in and day_count and
// stores the date or 2020-01-01 with load_rejected set, or an add
// (s_tuser high), which moves the date forward by day_count days.
// Each item gives one result item on the m_ channel with the date after
// and before the step and the two status flags in m_tuser.
// An accepted item first runs the leap test of its year (LEAP_MUL and
// LEAP_CHK); a load is then checked in CHECK, an add walks in WALK, and
// DONE writes the result register. An add takes longer for each month
// passed and each year boundary crossed, since one compare-and-subtract unit
// walks the date a month at a time and the leap test of each new year uses a
// registered multiply by the reciprocal of 25.
// s_tready is high only while no item is in work; one item is worked at a
// time, and the next one can be taken in the cycle after a result is written. A
// finished result waits in the output register while the next item is
// taken; a stalled receiver holds m_tvalid and m_tdata steady and the next
// result waits until that register frees.
// Reset (aresetn low, synchronous) sets the date to 0001-01-01 and
// empties the output register.
module calendar_date_day_adder #(
    parameter int MAX_YEAR  = cdda_pkg::MAX_YEAR_DEF,
    parameter int ADD_WIDTH = cdda_pkg::ADD_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year_in [13:0], month_in [17:14], day_count [33:18], zero [39:34]
    input  logic [39:0] s_tdata,
    // req_type [0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // year_now [13:0], month_now [17:14], day_now [22:18],
    // year_before [36:23], month_before [40:37], day_before [45:41], zero [47:46]
    output logic [47:0] m_tdata,
    // load_rejected [0], year_overflow [1]
    output logic [1:0]  m_tuser
);

    localparam int YW = cdda_pkg::YEAR_W;
    localparam int MW = cdda_pkg::MONTH_W;
    localparam int DW = cdda_pkg::DAY_W;
    localparam int AW = cdda_pkg::ACC_W;
    localparam int QW = cdda_pkg::QUOT_W;
    localparam int PW = YW + cdda_pkg::RECIP_W;
    localparam int CNT_W = (ADD_WIDTH < cdda_pkg::COUNT_W) ? ADD_WIDTH : cdda_pkg::COUNT_W;
    localparam logic [YW-1:0] MAX_YEAR_V = YW'(MAX_YEAR);

    cdda_pkg::state_t state_reg, state_next;

    logic [YW-1:0] year_reg, year_next;
    logic [MW-1:0] month_reg, month_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic          leap_reg, leap_next;
    logic [QW-1:0] quot_reg, quot_next;
    logic          req_reg, req_next;
    logic          rej_reg, rej_next;
    logic          ovf_reg, ovf_next;
    logic [YW-1:0] year_before_reg, year_before_next;
    logic [MW-1:0] month_before_reg, month_before_next;
    logic [DW-1:0] day_before_reg, day_before_next;

    logic          out_valid_reg, out_valid_next;
    logic [47:0]   out_data_reg, out_data_next;
    logic [1:0]    out_user_reg, out_user_next;

    logic          in_fire;
    logic          out_free;
    logic          load_ok;
    logic [PW-1:0] prod;
    logic [YW-1:0] rem25;
    logic          by25;
    logic [YW-1:0] year_in;
    logic [MW-1:0] month_in;
    logic [15:0]   day_count;

    cdda_pkg::walk_t walk;

    assign year_in   = s_tdata[13:0];
    assign month_in  = s_tdata[17:14];
    assign day_count = s_tdata[33:18];

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Shared month-length compare and subtract.
    cdda_month_walk u_walk (
        .month (month_reg),
        .leap  (leap_reg),
        .acc   (acc_reg),
        .walk  (walk)
    );

    // Leap test: registered quotient by 25 from the product, then remainder.
    assign prod  = PW'(year_reg) * PW'(cdda_pkg::RECIP_25);
    assign rem25 = year_reg - (YW'({quot_reg, 4'b0000}) + YW'({quot_reg, 3'b000})
                               + YW'(quot_reg));
    assign by25  = (rem25 == '0);

    // Checks of a loaded date; the walk unit supplies the day bound.
    assign load_ok = (year_reg != '0) && (year_reg <= MAX_YEAR_V)
                     && (month_reg >= cdda_pkg::JANUARY) && (month_reg <= cdda_pkg::DECEMBER)
                     && (acc_reg != '0) && walk.fits;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cdda_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = cdda_pkg::ST_LEAP_MUL;
                end
            end
            cdda_pkg::ST_LEAP_MUL: state_next = cdda_pkg::ST_LEAP_CHK;
            cdda_pkg::ST_LEAP_CHK: begin
                state_next = (req_reg == cdda_pkg::REQ_LOAD) ? cdda_pkg::ST_CHECK
                                                             : cdda_pkg::ST_WALK;
            end
            cdda_pkg::ST_CHECK: state_next = cdda_pkg::ST_DONE;
            cdda_pkg::ST_WALK: begin
                if (walk.fits) begin
                    state_next = cdda_pkg::ST_DONE;
                end else if (month_reg == cdda_pkg::DECEMBER) begin
                    state_next = (year_reg >= MAX_YEAR_V) ? cdda_pkg::ST_DONE
                                                          : cdda_pkg::ST_LEAP_MUL;
                end
            end
            cdda_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = cdda_pkg::ST_IDLE;
                end
            end
            default: state_next = cdda_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register updates for each state.
    always_comb begin
        year_next         = year_reg;
        month_next        = month_reg;
        acc_next          = acc_reg;
        leap_next         = leap_reg;
        quot_next         = quot_reg;
        req_next          = req_reg;
        rej_next          = rej_reg;
        ovf_next          = ovf_reg;
        year_before_next  = year_before_reg;
        month_before_next = month_before_reg;
        day_before_next   = day_before_reg;
        out_data_next     = out_data_reg;
        out_user_next     = out_user_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        s_tready          = 1'b0;

        unique case (state_reg)
            cdda_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    year_before_next  = year_reg;
                    month_before_next = month_reg;
                    day_before_next   = acc_reg[DW-1:0];
                    req_next          = s_tuser[0];
                    rej_next          = 1'b0;
                    ovf_next          = 1'b0;
                    if (s_tuser[0] == cdda_pkg::REQ_LOAD) begin
                        year_next  = year_in;
                        month_next = month_in;
                        acc_next   = AW'(day_count);
                    end else begin
                        acc_next = AW'(acc_reg[DW-1:0]) + AW'(day_count[CNT_W-1:0]);
                    end
                end
            end
            cdda_pkg::ST_LEAP_MUL: begin
                quot_next = prod[PW-1 -: QW];
            end
            cdda_pkg::ST_LEAP_CHK: begin
                leap_next = (year_reg[1:0] == 2'b00) && (!by25 || (year_reg[3:0] == 4'b0000));
            end
            cdda_pkg::ST_CHECK: begin
                if (!load_ok) begin
                    year_next  = cdda_pkg::FALLBACK_YEAR;
                    month_next = cdda_pkg::JANUARY;
                    acc_next   = AW'(cdda_pkg::FIRST_DAY);
                    rej_next   = 1'b1;
                end
            end
            cdda_pkg::ST_WALK: begin
                if (!walk.fits) begin
                    acc_next = walk.rest;
                    if (month_reg == cdda_pkg::DECEMBER) begin
                        if (year_reg >= MAX_YEAR_V) begin
                            // Carry past the top year: hold at its last day.
                            year_next  = MAX_YEAR_V;
                            month_next = cdda_pkg::DECEMBER;
                            acc_next   = AW'(cdda_pkg::LAST_DAY);
                            ovf_next   = 1'b1;
                        end else begin
                            year_next  = year_reg + YW'(1);
                            month_next = cdda_pkg::JANUARY;
                        end
                    end else begin
                        month_next = month_reg + MW'(1);
                    end
                end
            end
            cdda_pkg::ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, day_before_reg, month_before_reg, year_before_reg,
                                      acc_reg[DW-1:0], month_reg, year_reg};
                    out_user_next  = {ovf_reg, rej_reg};
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cdda_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            year_reg      <= YW'(1);
            month_reg     <= cdda_pkg::JANUARY;
            acc_reg       <= AW'(cdda_pkg::FIRST_DAY);
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            acc_reg       <= acc_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        leap_reg         <= leap_next;
        quot_reg         <= quot_next;
        req_reg          <= req_next;
        rej_reg          <= rej_next;
        ovf_reg          <= ovf_next;
        year_before_reg  <= year_before_next;
        month_before_reg <= month_before_next;
        day_before_reg   <= day_before_next;
        out_data_reg     <= out_data_next;
        out_user_reg     <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // An accepted item always starts with the leap test of its year.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == cdda_pkg::ST_LEAP_MUL))
        else $error("item accepted without starting the leap test");

    // The walk only runs on a real month.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cdda_pkg::ST_WALK) |->
            (month_reg >= cdda_pkg::JANUARY) && (month_reg <= cdda_pkg::DECEMBER))
        else $error("walk reached a month code out of range");

    // A rejected load reports the fallback date.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[13:0] == cdda_pkg::FALLBACK_YEAR) && (m_tdata[17:14] == cdda_pkg::JANUARY)
            && (m_tdata[22:18] == cdda_pkg::FIRST_DAY))
        else $error("rejected load without the fallback date");

    // A saturated add reports the last day of the top year.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |->
            (m_tdata[13:0] == MAX_YEAR_V) && (m_tdata[17:14] == cdda_pkg::DECEMBER)
            && (m_tdata[22:18] == cdda_pkg::LAST_DAY) && !m_tuser[0])
        else $error("overflow flag without the saturated date");

endmodule

### bench/calendar_date_day_adder_tb.sv
`timescale 1ns / 100ps

module calendar_date_day_adder_tb;

    localparam int MAX_YR       = cdda_pkg::MAX_YEAR_DEF;
    localparam int FALLBACK_YR  = 2020;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int TAIL_ITEMS   = 100;
    localparam int RANDOM_ITEMS = 925;
    localparam int SETTLE_WAIT  = 3000;
    localparam int HOLD_AT      = 250;
    localparam int HOLD_CYCLES  = 400;

    // One request as queued for the driver; a drain entry holds the sender
    // until every outstanding result has come back.
    typedef struct {
        bit                           drain;
        cdda_pkg::req_t               kind;
        logic [cdda_pkg::YEAR_W-1:0]  year;
        logic [cdda_pkg::MONTH_W-1:0] month;
        logic [cdda_pkg::COUNT_W-1:0] count;
    } date_req_t;

    typedef struct packed {
        logic [cdda_pkg::YEAR_W-1:0]  year_now;
        logic [cdda_pkg::MONTH_W-1:0] month_now;
        logic [cdda_pkg::DAY_W-1:0]   day_now;
        logic [cdda_pkg::YEAR_W-1:0]  year_before;
        logic [cdda_pkg::MONTH_W-1:0] month_before;
        logic [cdda_pkg::DAY_W-1:0]   day_before;
        logic                         load_rejected;
        logic                         year_overflow;
    } date_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    date_req_t    pending_items[$];
    date_result_t expected_dates[$];
    date_req_t    held_item;

    // Predicted date held by the block.
    int unsigned cal_year;
    int unsigned cal_month;
    int unsigned cal_day;

    int unsigned month_len_tbl[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    int send_gap;
    int stall_left;
    int items_accepted;
    int results_seen;
    int error_count;
    int cycle_count;
    int n_loads;
    int n_adds;
    int n_rejected;
    int n_saturated;
    logic hold_on;
    int   hold_left;
    bit   hold_done;

    calendar_date_day_adder #(
        .MAX_YEAR  (MAX_YR),
        .ADD_WIDTH (cdda_pkg::ADD_WIDTH_DEF)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock and reset.
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_of_month(input int unsigned y, input int unsigned m);
        int unsigned len;
        if (m < 1 || m > 12) begin
            return 0;
        end
        len = month_len_tbl[m];
        if (m == 2 && is_leap_year(y)) begin
            len = len + 1;
        end
        return len;
    endfunction

    // Applies one request to the predicted date and returns the result item.
    function automatic date_result_t advance_date(input date_req_t item);
        date_result_t r;
        int unsigned  y;
        int unsigned  m;
        int unsigned  d;
        int unsigned  len;
        r = '0;
        r.year_before  = cdda_pkg::YEAR_W'(cal_year);
        r.month_before = cdda_pkg::MONTH_W'(cal_month);
        r.day_before   = cdda_pkg::DAY_W'(cal_day);
        if (item.kind == cdda_pkg::REQ_LOAD) begin
            if (item.year >= 1 && item.year <= MAX_YR && item.month >= 1 && item.month <= 12
                && item.count >= 1 && item.count <= days_of_month(item.year, item.month)) begin
                cal_year  = item.year;
                cal_month = item.month;
                cal_day   = item.count;
            end else begin
                cal_year  = FALLBACK_YR;
                cal_month = 1;
                cal_day   = 1;
                r.load_rejected = 1'b1;
            end
        end else begin
            // Walk forward one month at a time, saturating past the top year.
            y   = cal_year;
            m   = cal_month;
            d   = cal_day + item.count;
            len = days_of_month(y, m);
            while (d > len) begin
                d = d - len;
                m = m + 1;
                if (m == 13) begin
                    m = 1;
                    y = y + 1;
                    if (y > MAX_YR) begin
                        y = MAX_YR;
                        m = 12;
                        d = 31;
                        r.year_overflow = 1'b1;
                        break;
                    end
                end
                len = days_of_month(y, m);
            end
            cal_year  = y;
            cal_month = m;
            cal_day   = d;
        end
        r.year_now  = cdda_pkg::YEAR_W'(cal_year);
        r.month_now = cdda_pkg::MONTH_W'(cal_month);
        r.day_now   = cdda_pkg::DAY_W'(cal_day);
        return r;
    endfunction

    // Random idling is off near the end of the run and in calm stretches.
    function automatic bit idle_ok();
        return (pending_items.size() >= TAIL_ITEMS) && ((items_accepted / 120) % 4 != 3);
    endfunction

    function automatic void queue_load(input int unsigned y, input int unsigned m,
                                       input int unsigned d);
        date_req_t item;
        item.drain = 1'b0;
        item.kind  = cdda_pkg::REQ_LOAD;
        item.year  = cdda_pkg::YEAR_W'(y);
        item.month = cdda_pkg::MONTH_W'(m);
        item.count = cdda_pkg::COUNT_W'(d);
        pending_items.push_back(item);
    endfunction

    function automatic void queue_add(input int unsigned cnt);
        date_req_t item;
        item.drain = 1'b0;
        item.kind  = cdda_pkg::REQ_ADD;
        item.year  = cdda_pkg::YEAR_W'($urandom);
        item.month = cdda_pkg::MONTH_W'($urandom);
        item.count = cdda_pkg::COUNT_W'(cnt);
        pending_items.push_back(item);
    endfunction

    function automatic void queue_drain();
        date_req_t item;
        item.drain = 1'b1;
        item.kind  = cdda_pkg::REQ_LOAD;
        item.year  = '0;
        item.month = '0;
        item.count = '0;
        pending_items.push_back(item);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Driver: offers queued items, keeps each one steady until it is taken.
    always @(posedge aclk) begin : drive_proc
        date_result_t res;
        logic         offer;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= '0;
            cal_year  = 1;
            cal_month = 1;
            cal_day   = 1;
            send_gap  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                res = advance_date(held_item);
                expected_dates.push_back(res);
                items_accepted++;
                if (held_item.kind == cdda_pkg::REQ_LOAD) begin
                    n_loads++;
                end else begin
                    n_adds++;
                end
                n_rejected  += res.load_rejected;
                n_saturated += res.year_overflow;
            end
            offer = s_tvalid && !s_tready;
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() != 0) begin
                    if (pending_items[0].drain) begin
                        if (expected_dates.size() == 0) begin
                            void'(pending_items.pop_front());
                        end
                    end else if (idle_ok() && !hold_on && $urandom_range(0, 4) == 0) begin
                        send_gap = $urandom_range(1, 14) - 1;
                    end else begin
                        held_item = pending_items.pop_front();
                        offer     = 1'b1;
                        s_tdata   <= {6'b0, held_item.count, held_item.month, held_item.year};
                        s_tuser   <= held_item.kind;
                    end
                end
            end
            s_tvalid <= offer;
        end
    end

    // Long receiver hold-off so that the block fills up and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_on   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_on   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1) begin
                hold_on <= 1'b0;
            end
        end
    end

    // Monitor: checks each result item against the oldest prediction.
    always @(posedge aclk) begin : monitor_proc
        date_result_t want;
        logic         ready_next;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_dates.size() == 0) begin
                    report_mismatch("unexpected result item, year_now", m_tdata[13:0], 0);
                end else begin
                    want = expected_dates.pop_front();
                    check_field("year_now", m_tdata[13:0], want.year_now);
                    check_field("month_now", m_tdata[17:14], want.month_now);
                    check_field("day_now", m_tdata[22:18], want.day_now);
                    check_field("year_before", m_tdata[36:23], want.year_before);
                    check_field("month_before", m_tdata[40:37], want.month_before);
                    check_field("day_before", m_tdata[45:41], want.day_before);
                    check_field("load_rejected", m_tuser[0], want.load_rejected);
                    check_field("year_overflow", m_tuser[1], want.year_overflow);
                end
            end
            if (hold_on) begin
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (idle_ok() && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

    // Run-time guard.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus_proc
        int          sel;
        int unsigned y;
        int unsigned m;
        date_req_t   noise;
        // Directed part: reset date, leap rules, invalid loads, extremes.
        queue_add(0);
        queue_load(2024, 2, 29);
        queue_load(2023, 2, 29);
        queue_load(1900, 2, 29);
        queue_load(2000, 2, 29);
        queue_load(0, 5, 10);
        queue_load(10000, 1, 1);
        queue_load(16383, 15, 65535);
        queue_load(2021, 0, 1);
        queue_load(2021, 13, 1);
        queue_load(2021, 4, 31);
        queue_load(2021, 1, 0);
        queue_load(2021, 1, 32);
        queue_load(1, 1, 1);
        queue_add(65535);
        queue_load(9999, 12, 31);
        queue_add(1);
        queue_load(9999, 12, 1);
        queue_add(65535);
        queue_load(2000, 2, 28);
        queue_add(1);
        queue_add(1);
        queue_load(9998, 12, 31);
        queue_add(365);
        queue_add(0);
        queue_drain();

        // Random part: mostly valid loads and adds, some noise loads.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 400 || i == 700) begin
                queue_drain();
            end
            sel = $urandom_range(0, 99);
            if (sel < 22) begin
                if ($urandom_range(0, 3) == 0) begin
                    y = $urandom_range(9985, MAX_YR);
                end else if ($urandom_range(0, 2) == 0) begin
                    y = 4 * $urandom_range(1, MAX_YR / 4);
                end else begin
                    y = $urandom_range(1, MAX_YR);
                end
                m = $urandom_range(1, 12);
                queue_load(y, m, $urandom_range(1, days_of_month(y, m)));
            end else if (sel < 30) begin
                noise.drain = 1'b0;
                noise.kind  = cdda_pkg::REQ_LOAD;
                noise.year  = cdda_pkg::YEAR_W'($urandom);
                noise.month = cdda_pkg::MONTH_W'($urandom);
                noise.count = cdda_pkg::COUNT_W'($urandom);
                pending_items.push_back(noise);
            end else if (sel < 78) begin
                queue_add($urandom_range(0, 40));
            end else if (sel < 98) begin
                queue_add($urandom_range(41, 1500));
            end else begin
                queue_add($urandom_range(1501, 65535));
            end
        end

        @(posedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_dates.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_WAIT) @(posedge aclk);

        $display("Checked %0d results: %0d loads (%0d rejected), %0d adds (%0d saturated).",
                 results_seen, n_loads, n_rejected, n_adds, n_saturated);
        $display("Sender gaps, receiver stalls, one long hold-off and drain pauses were applied.");
        if (error_count == 0 && expected_dates.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
